@@ src/ring_exclusion_hop_engine_unit_assert.svh @@
// assertion helpers shared by the ring exclusion hop engine
`ifndef RING_EXCLUSION_HOP_ENGINE_UNIT_ASSERT_SVH
`define RING_EXCLUSION_HOP_ENGINE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define REXH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define REXH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rexh_pkg.sv @@
package rexh_pkg;

  // default sizes
  localparam int MAX_SITES_DEF   = 1024;
  localparam int MAX_SPECIES_DEF = 4;
  localparam int DRAW_BITS_DEF   = 16;

  // field widths
  localparam int MODE_W     = 2;
  localparam int SITE_W     = 10;
  localparam int SPEC_W     = 2;
  localparam int RATE_W     = 17;
  localparam int DRAW_W     = 16;
  localparam int RING_LEN_W = 11;
  localparam int SPC_CNT_W  = 3;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int STATUS_W   = 2;

  // threshold is a fraction of one with this many fraction bits
  localparam int RATE_FRAC_BITS = 16;
  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

  localparam logic [RING_LEN_W-1:0] RING_LEN_RST = RING_LEN_W'(1024);
  localparam logic [SPC_CNT_W-1:0]  SPC_CNT_RST  = SPC_CNT_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_HOP     = 2'd0,
    MODE_WR_SITE = 2'd1,
    MODE_RD_SITE = 2'd2,
    MODE_WR_THR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SKIP  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_LENGTH   = 1'd0,
    CFG_SPECIES_COUNT = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [DRAW_W-1:0] uniform_draw;
    logic [RATE_W-1:0] rate_value;
    logic [SPEC_W-1:0] other_species;
    logic [SPEC_W-1:0] species_value;
    logic [SITE_W-1:0] site;
    mode_t             mode;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              hopped;
    logic [SPEC_W-1:0] read_species;
  } res_t;

endpackage

@@ src/rexh_ram.sv @@
module rexh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/rexh_thr_table.sv @@
module rexh_thr_table #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rexh_pkg::RATE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rexh_pkg::RATE_W-1:0] rdata
);
  import rexh_pkg::*;

  logic [DEPTH-1:0]  valid;
  logic              rd_valid;
  logic [RATE_W-1:0] ram_q;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  rexh_ram #(
    .WIDTH (RATE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr),
    .raddr_b (raddr),
    .rdata_a (ram_q),
    .rdata_b ()
  );

  assign rdata = rd_valid ? ram_q : '0;

endmodule

@@ src/rexh_hop_ctrl.sv @@
module rexh_hop_ctrl #(
  parameter int MAX_SITES   = rexh_pkg::MAX_SITES_DEF,
  parameter int MAX_SPECIES = rexh_pkg::MAX_SPECIES_DEF,
  parameter int DRAW_BITS   = rexh_pkg::DRAW_BITS_DEF,
  localparam int LEN_W = ($clog2(MAX_SITES + 1) > rexh_pkg::RING_LEN_W) ?
                         $clog2(MAX_SITES + 1) : rexh_pkg::RING_LEN_W,
  localparam int NSP_W = ($clog2(MAX_SPECIES + 1) > rexh_pkg::SPC_CNT_W) ?
                         $clog2(MAX_SPECIES + 1) : rexh_pkg::SPC_CNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rexh_pkg::req_t       in_req,
  input  logic [LEN_W-1:0]     used_len,
  input  logic [NSP_W-1:0]     used_nsp,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rexh_pkg::res_t       res
);
  import rexh_pkg::*;
  `include "ring_exclusion_hop_engine_unit_assert.svh"

  localparam int ADDR_W   = $clog2(MAX_SITES);
  localparam int TH_DEPTH = MAX_SPECIES * MAX_SPECIES;
  localparam int TH_AW    = $clog2(TH_DEPTH);
  localparam int CMP_W    = DRAW_BITS + RATE_W;
  localparam logic [DRAW_W-1:0] DRAW_MASK = (DRAW_BITS >= DRAW_W) ? '1 :
                                            DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RING = 5'b00010,
    S_THR  = 5'b00100,
    S_SWAP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state, state_next;
  req_t               req_q;
  res_t               res_q, res_next;
  logic [ADDR_W-1:0]  nxt_q;
  logic [SPEC_W-1:0]  a_q, b_q;

  logic               accept;
  logic [LEN_W-1:0]   site_ext, site_inc, nxt_in;
  logic [SPEC_W-1:0]  ring_a, ring_b;
  logic               ring_we;
  logic [ADDR_W-1:0]  ring_waddr;
  logic [SPEC_W-1:0]  ring_wdata;
  logic               thr_we;
  logic [TH_AW-1:0]   thr_waddr, thr_raddr;
  logic [RATE_W-1:0]  thr_rdata;
  logic               site_bad, a_bad, b_bad, sval_bad, oval_bad;
  logic [CMP_W-1:0]   draw_scaled, thr_scaled;

  function automatic logic [TH_AW-1:0] th_index(input logic [SPEC_W-1:0] row,
                                                input logic [SPEC_W-1:0] col);
    return TH_AW'(int'(row) * MAX_SPECIES + int'(col));
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  // clockwise neighbor wraps to site zero at the ring length
  assign site_ext = LEN_W'(in_req.site);
  assign site_inc = site_ext + LEN_W'(1);
  assign nxt_in   = (site_inc == used_len) ? '0 : site_inc;

  rexh_ram #(
    .WIDTH (SPEC_W),
    .DEPTH (MAX_SITES)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (ring_wdata),
    .raddr_a (site_ext[ADDR_W-1:0]),
    .raddr_b (nxt_in[ADDR_W-1:0]),
    .rdata_a (ring_a),
    .rdata_b (ring_b)
  );

  rexh_thr_table #(
    .DEPTH (TH_DEPTH)
  ) u_thr (
    .clk   (clk),
    .rst   (rst),
    .we    (thr_we),
    .waddr (thr_waddr),
    .wdata (req_q.rate_value),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  assign site_bad  = (LEN_W'(req_q.site) >= used_len);
  assign a_bad     = (NSP_W'(ring_a) >= used_nsp);
  assign b_bad     = (NSP_W'(ring_b) >= used_nsp);
  assign sval_bad  = (NSP_W'(req_q.species_value) >= used_nsp);
  assign oval_bad  = (NSP_W'(req_q.other_species) >= used_nsp);
  assign thr_raddr = th_index(ring_a, ring_b);
  assign thr_waddr = th_index(req_q.species_value, req_q.other_species);

  // draw / 2^DRAW_BITS < thr / 2^16, cross multiplied
  assign draw_scaled = CMP_W'(req_q.uniform_draw & DRAW_MASK) << RATE_FRAC_BITS;
  assign thr_scaled  = CMP_W'(thr_rdata) << DRAW_BITS;

  always_comb begin
    state_next = state;
    res_next   = res_q;
    ring_we    = 1'b0;
    ring_waddr = ADDR_W'(req_q.site);
    ring_wdata = req_q.species_value;
    thr_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next   = '{status: ST_OK, hopped: 1'b0, read_species: '0};
          state_next = S_RING;
        end
      end
      S_RING: begin
        state_next = S_DONE;
        unique case (req_q.mode)
          MODE_HOP: begin
            if (site_bad || a_bad || b_bad) begin
              res_next.status = ST_RANGE;
            end else if (ring_a == ring_b) begin
              res_next.status = ST_SKIP;
            end else begin
              state_next = S_THR;
            end
          end
          MODE_WR_SITE: begin
            if (site_bad || sval_bad) begin
              res_next.status = ST_RANGE;
            end else begin
              ring_we = 1'b1;
            end
          end
          MODE_RD_SITE: begin
            if (site_bad) begin
              res_next.status = ST_RANGE;
            end else begin
              res_next.read_species = ring_a;
            end
          end
          MODE_WR_THR: begin
            if (sval_bad || oval_bad || (req_q.rate_value > RATE_ONE)) begin
              res_next.status = ST_RANGE;
            end else begin
              thr_we = 1'b1;
            end
          end
          default: begin
            res_next.status = ST_RANGE;
          end
        endcase
      end
      S_THR: begin
        if (draw_scaled < thr_scaled) begin
          ring_we         = 1'b1;
          ring_wdata      = b_q;
          res_next.hopped = 1'b1;
          state_next      = S_SWAP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SWAP: begin
        ring_we    = 1'b1;
        ring_waddr = nxt_q;
        ring_wdata = a_q;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
    if (accept) begin
      req_q <= in_req;
      nxt_q <= nxt_in[ADDR_W-1:0];
    end
    if (state == S_RING) begin
      a_q <= ring_a;
      b_q <= ring_b;
    end
  end

  `REXH_ASSERT_NEXT(a_accept_reads, clk, rst, accept, state == S_RING,
                    "accepted request did not move to ring read")
  `REXH_ASSERT_NEXT(a_swap_done, clk, rst, state == S_SWAP, state == S_DONE,
                    "neighbor write not followed by result")
  `REXH_ASSERT_SAME(a_hop_ok, clk, rst, (state == S_DONE) && res_q.hopped,
                    (res_q.status == ST_OK) && (req_q.mode == MODE_HOP),
                    "swap reported outside a clean hop")
  `REXH_ASSERT_SAME(a_read_mode, clk, rst,
                    (state == S_DONE) && (res_q.read_species != '0),
                    req_q.mode == MODE_RD_SITE,
                    "read label reported outside read mode")
  `REXH_ASSERT_SAME(a_write_states, clk, rst, ring_we,
                    (state == S_RING) || (state == S_THR) || (state == S_SWAP),
                    "ring written outside a working state")

endmodule

@@ src/ring_exclusion_hop_engine_unit.sv @@
// channel   direction  payload
// s_*       in         s_tuser: mode; s_tdata: site, species_value, other_species,
//                      rate_value, uniform_draw
// m_*       out        m_tdata: read_species, hopped; m_tuser: status
// cfg_*     in         register index and write data, no read-back
//
// a hop that swaps runs from request to the next request through ring pair read,
// threshold read, site write, neighbor write and hand-over to the output register;
// a refused hop leaves out both writes, and a skipped or out-of-range hop goes from
// the ring pair read straight to hand-over, as do site write, site read and threshold
// write; the single write port of the ring memory makes a hop write site and neighbor in turn.
// synchronous reset clears control, threshold valid bits, ring_length to 1024 and
// species_count to 3; the ring holds no reset and needs no clearing pass.
// a result waits in the output register; the engine stalls in its last step
// only while that register is still full.
module ring_exclusion_hop_engine_unit #(
  parameter int MAX_SITES   = rexh_pkg::MAX_SITES_DEF,
  parameter int MAX_SPECIES = rexh_pkg::MAX_SPECIES_DEF,
  parameter int DRAW_BITS   = rexh_pkg::DRAW_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // site[9:0], species_value[11:10], other_species[13:12], rate_value[30:14],
  // uniform_draw[46:31], zero[47]
  input  logic [47:0]                    s_tdata,
  // mode[1:0]
  input  logic [rexh_pkg::MODE_W-1:0]    s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // read_species[1:0], hopped[2], zero[7:3]
  output logic [7:0]                     m_tdata,
  // status[1:0]
  output logic [rexh_pkg::STATUS_W-1:0]  m_tuser,
  input  logic                           cfg_we,
  input  logic [rexh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rexh_pkg::CFG_W-1:0]     cfg_wdata
);
  import rexh_pkg::*;

  localparam int LEN_W = ($clog2(MAX_SITES + 1) > RING_LEN_W) ?
                         $clog2(MAX_SITES + 1) : RING_LEN_W;
  localparam int NSP_W = ($clog2(MAX_SPECIES + 1) > SPC_CNT_W) ?
                         $clog2(MAX_SPECIES + 1) : SPC_CNT_W;

  logic [RING_LEN_W-1:0] ring_length;
  logic [SPC_CNT_W-1:0]  species_count;
  logic [LEN_W-1:0]      len_ext, used_len;
  logic [NSP_W-1:0]      nsp_ext, used_nsp;
  req_t                  req;
  res_t                  res, res_out;
  logic                  res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length   <= RING_LEN_RST;
      species_count <= SPC_CNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RING_LENGTH:   ring_length   <= cfg_wdata[RING_LEN_W-1:0];
        CFG_SPECIES_COUNT: species_count <= cfg_wdata[SPC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // registers are used clamped to their meaningful range
  assign len_ext  = LEN_W'(ring_length);
  assign used_len = (len_ext < LEN_W'(2)) ? LEN_W'(2) :
                    (len_ext > LEN_W'(MAX_SITES)) ? LEN_W'(MAX_SITES) : len_ext;
  assign nsp_ext  = NSP_W'(species_count);
  assign used_nsp = (nsp_ext < NSP_W'(2)) ? NSP_W'(2) :
                    (nsp_ext > NSP_W'(MAX_SPECIES)) ? NSP_W'(MAX_SPECIES) : nsp_ext;

  assign req.mode          = mode_t'(s_tuser);
  assign req.site          = s_tdata[9:0];
  assign req.species_value = s_tdata[11:10];
  assign req.other_species = s_tdata[13:12];
  assign req.rate_value    = s_tdata[30:14];
  assign req.uniform_draw  = s_tdata[46:31];

  rexh_hop_ctrl #(
    .MAX_SITES   (MAX_SITES),
    .MAX_SPECIES (MAX_SPECIES),
    .DRAW_BITS   (DRAW_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .used_len  (used_len),
    .used_nsp  (used_nsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_out <= res;
    end
  end

  assign m_tdata = {5'b0, res_out.hopped, res_out.read_species};
  assign m_tuser = res_out.status;

endmodule

@@ sim/ring_exclusion_hop_engine_unit_tb.sv @@
`timescale 1ns / 100ps

module ring_exclusion_hop_engine_unit_tb;
  import rexh_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 220;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TICKS = 8;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    req_t               req;
    logic               typed;
    res_t               outcome;
    cfg_idx_t           idx;
    logic [CFG_W-1:0]   data;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // engine state as the testbench sees it
  logic [SPEC_W-1:0]     ring_model [MAX_SITES_DEF];
  logic [RATE_W-1:0]     thr_model [MAX_SPECIES_DEF * MAX_SPECIES_DEF];
  bit                    site_written [MAX_SITES_DEF];
  logic [RING_LEN_W-1:0] ring_len_reg = RING_LEN_RST;
  logic [SPC_CNT_W-1:0]  species_reg = SPC_CNT_RST;

  res_t                  pending_outcomes [$];
  stim_row_t             stim_table [$];
  int unsigned           err_count = 0;
  int unsigned           results_seen = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           burst_left = 1;
  int unsigned           win_base = 0;
  int unsigned           rx_tick = 0;

  ring_exclusion_hop_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned ring_len_now();
    int unsigned n;
    n = ring_len_reg;
    if (n < 2) n = 2;
    if (n > MAX_SITES_DEF) n = MAX_SITES_DEF;
    return n;
  endfunction

  function automatic int unsigned species_now();
    int unsigned n;
    n = species_reg;
    if (n < 2) n = 2;
    if (n > MAX_SPECIES_DEF) n = MAX_SPECIES_DEF;
    return n;
  endfunction

  // applies one request to the state copy and returns its result
  function automatic res_t hop_outcome(req_t r);
    res_t        o;
    int unsigned len, nsp, nxt, a, b;
    len = ring_len_now();
    nsp = species_now();
    o.read_species = '0;
    o.hopped = 1'b0;
    o.status = ST_OK;
    case (r.mode)
      MODE_HOP: begin
        if (r.site >= len) begin
          o.status = ST_RANGE;
        end else begin
          nxt = (r.site + 1 == len) ? 0 : r.site + 1;
          a = ring_model[r.site];
          b = ring_model[nxt];
          if (a >= nsp || b >= nsp) begin
            o.status = ST_RANGE;
          end else if (a == b) begin
            o.status = ST_SKIP;
          end else if (r.uniform_draw < thr_model[a * MAX_SPECIES_DEF + b]) begin
            ring_model[r.site] = SPEC_W'(b);
            ring_model[nxt] = SPEC_W'(a);
            o.hopped = 1'b1;
          end
        end
      end
      MODE_WR_SITE: begin
        if (r.site >= len || r.species_value >= nsp) begin
          o.status = ST_RANGE;
        end else begin
          ring_model[r.site] = r.species_value;
          site_written[r.site] = 1'b1;
        end
      end
      MODE_RD_SITE: begin
        if (r.site >= len) o.status = ST_RANGE;
        else o.read_species = ring_model[r.site];
      end
      default: begin
        if (r.species_value >= nsp || r.other_species >= nsp || r.rate_value > RATE_ONE)
          o.status = ST_RANGE;
        else
          thr_model[r.species_value * MAX_SPECIES_DEF + r.other_species] = r.rate_value;
      end
    endcase
    return o;
  endfunction

  function automatic void row_item(mode_t m, int unsigned site, int unsigned sv,
                                   int unsigned ov, int unsigned rate, int unsigned draw,
                                   logic typed, status_t st, logic hop, int unsigned rd);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.req.mode = m;
    row.req.site = SITE_W'(site);
    row.req.species_value = SPEC_W'(sv);
    row.req.other_species = SPEC_W'(ov);
    row.req.rate_value = RATE_W'(rate);
    row.req.uniform_draw = DRAW_W'(draw);
    row.typed = typed;
    row.outcome.status = st;
    row.outcome.hopped = hop;
    row.outcome.read_species = SPEC_W'(rd);
    row.idx = CFG_RING_LENGTH;
    row.data = '0;
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic void row_cfg(cfg_idx_t idx, int unsigned data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.req = '0;
    row.typed = 1'b0;
    row.outcome = '0;
    row.idx = idx;
    row.data = CFG_W'(data);
    stim_table.insert(stim_table.size(), row);
  endfunction

  // mostly well-formed traffic around a window of written sites
  function automatic req_t gen_request();
    req_t        r;
    int unsigned len, nsp, pick, site, nxt;
    len = ring_len_now();
    nsp = species_now();
    pick = $urandom_range(0, 99);
    if (pick < 70) site = (win_base + $urandom_range(0, 15)) % len;
    else if (pick < 88) site = $urandom_range(0, len - 1);
    else site = $urandom_range(0, MAX_SITES_DEF - 1);
    r.site = SITE_W'(site);
    r.species_value = ($urandom_range(0, 99) < 92) ? SPEC_W'($urandom_range(0, nsp - 1))
                                                   : SPEC_W'($urandom_range(0, 3));
    r.other_species = ($urandom_range(0, 99) < 92) ? SPEC_W'($urandom_range(0, nsp - 1))
                                                   : SPEC_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 10) r.rate_value = RATE_ONE;
    else if (pick < 18) r.rate_value = '0;
    else if (pick < 25) r.rate_value = RATE_W'($urandom_range(65537, 131071));
    else r.rate_value = RATE_W'($urandom_range(0, 65535));
    r.uniform_draw = DRAW_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) r.mode = MODE_HOP;
    else if (pick < 70) r.mode = MODE_WR_SITE;
    else if (pick < 85) r.mode = MODE_RD_SITE;
    else r.mode = MODE_WR_THR;
    // never touch a site that holds no label yet
    if ((r.mode == MODE_HOP || r.mode == MODE_RD_SITE) && site < len) begin
      nxt = (site + 1 == len) ? 0 : site + 1;
      if (!site_written[site] || (r.mode == MODE_HOP && !site_written[nxt]))
        r.mode = MODE_WR_SITE;
    end
    return r;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input res_t given);
    res_t pred;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, r.uniform_draw, r.rate_value, r.other_species, r.species_value, r.site};
    s_tuser <= r.mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = hop_outcome(r);
    pending_outcomes.insert(pending_outcomes.size(), typed ? given : pred);
  endtask

  task automatic pace_sender(input bit no_gaps);
    int unsigned gap;
    burst_left--;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // registers change only with the engine drained
  task automatic settle_and_write(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_RING_LENGTH) ring_len_reg = data[RING_LEN_W-1:0];
    else species_reg = data[SPC_CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    err_count++;
  endtask

  // receiver stall pattern rotates through four modes over the run
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case ((rx_tick / 300) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= (rx_tick % 4) != 3;
      2: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (rx_tick % 11) < 3;
    endcase
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata %h tuser %h", m_tdata, m_tuser));
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata[1:0] != want.read_species)
          report_mismatch($sformatf("read_species %0d want %0d", m_tdata[1:0],
                                    want.read_species));
        if (m_tdata[2] != want.hopped)
          report_mismatch($sformatf("hopped %0d want %0d", m_tdata[2], want.hopped));
        if (m_tuser != want.status)
          report_mismatch($sformatf("status %0d want %0d", m_tuser, want.status));
        if (m_tdata[7:3] != '0)
          report_mismatch($sformatf("tdata padding %h", m_tdata[7:3]));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("ring_exclusion_hop_engine_unit_tb failed");
    $finish;
  end

  initial begin
    int unsigned len_list [PHASES] = '{2, 2047, 0, 1024, 13, 1, 700, 0};
    int unsigned spc_list [PHASES] = '{2, 7, 0, 4, 3, 1, 5, 0};
    int unsigned len_raw, spc_raw, len;
    req_t        r;
    foreach (ring_model[i]) ring_model[i] = '0;
    foreach (thr_model[i]) thr_model[i] = '0;
    foreach (site_written[i]) site_written[i] = 1'b0;

    // thresholds at both ends and out of range
    row_item(MODE_WR_THR, 0, 0, 1, 65536, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_THR, 0, 1, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_THR, 0, 2, 1, 40000, 0, 1'b0, ST_OK, 1'b0, 0);
    row_item(MODE_WR_THR, 0, 2, 2, 131071, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_WR_THR, 0, 3, 0, 5, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_WR_THR, 0, 0, 3, 5, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_WR_SITE, 0, 0, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_SITE, 1, 1, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_SITE, 1023, 2, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_SITE, 5, 3, 0, 0, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_RD_SITE, 1023, 0, 0, 0, 0, 1'b1, ST_OK, 1'b0, 2);
    // full threshold takes the largest draw, zero threshold refuses the smallest
    row_item(MODE_HOP, 0, 0, 0, 0, 65535, 1'b1, ST_OK, 1'b1, 0);
    row_item(MODE_HOP, 0, 0, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    // last site pairs with site zero
    row_item(MODE_HOP, 1023, 0, 0, 0, 0, 1'b0, ST_OK, 1'b0, 0);
    row_item(MODE_RD_SITE, 0, 0, 0, 0, 0, 1'b0, ST_OK, 1'b0, 0);
    row_item(MODE_WR_SITE, 2, 0, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_HOP, 1, 0, 0, 0, 12345, 1'b1, ST_SKIP, 1'b0, 0);
    // stored label beyond a lowered species count
    row_cfg(CFG_SPECIES_COUNT, 4);
    row_item(MODE_WR_SITE, 4, 3, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_WR_SITE, 3, 1, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_cfg(CFG_SPECIES_COUNT, 2);
    row_item(MODE_HOP, 3, 0, 0, 0, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_RD_SITE, 4, 0, 0, 0, 0, 1'b1, ST_OK, 1'b0, 3);
    // short ring: sites past the end
    row_cfg(CFG_RING_LENGTH, 8);
    row_item(MODE_RD_SITE, 8, 0, 0, 0, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_WR_SITE, 1023, 0, 0, 0, 0, 1'b1, ST_RANGE, 1'b0, 0);
    row_item(MODE_WR_SITE, 7, 1, 0, 0, 0, 1'b1, ST_OK, 1'b0, 0);
    row_item(MODE_HOP, 7, 0, 0, 0, 0, 1'b0, ST_OK, 1'b0, 0);
    row_item(MODE_HOP, 1023, 0, 0, 0, 0, 1'b1, ST_RANGE, 1'b0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        settle_and_write(stim_table[i].idx, stim_table[i].data);
      end else begin
        send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].outcome);
        pace_sender(1'b0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      len_raw = (p == PHASES - 1) ? $urandom_range(0, 2047) : len_list[p];
      spc_raw = (p == PHASES - 1) ? $urandom_range(0, 7) : spc_list[p];
      settle_and_write(CFG_RING_LENGTH, CFG_W'(len_raw));
      settle_and_write(CFG_SPECIES_COUNT, CFG_W'(spc_raw));
      len = ring_len_now();
      // some phases keep the window across the wrap point
      win_base = (len > 16 && $urandom_range(0, 1)) ? len - 8 : $urandom_range(0, len - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = gen_request();
        send_request(r, 1'b0, '0);
        pace_sender(p % 3 == 1);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_TICKS) @(posedge clk);
    if (err_count == 0 && pending_outcomes.size() == 0)
      $display("ring_exclusion_hop_engine_unit_tb passed");
    else
      $display("ring_exclusion_hop_engine_unit_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/rexh_pkg.sv
src/rexh_ram.sv
src/rexh_thr_table.sv
src/rexh_hop_ctrl.sv
src/ring_exclusion_hop_engine_unit.sv
sim/ring_exclusion_hop_engine_unit_tb.sv
